// ===== rtl/lirs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_pkg : shared types and constants of the linear-interpolation resampler
// Mode codes, output select codes, register indexes and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lirs_pkg;

    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_MAX_OUTPUTS = 2;

    localparam int RATE_BITS     = 16;   // width of both rate registers
    localparam int PH_BITS       = 40;   // phase accumulator width
    localparam int MUL_SPLIT     = 20;   // low slice of the phase difference per multiply
    localparam int DIV_STEP_BITS = 4;    // quotient bits retired per divider cycle

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_RATE  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_RATE = 1'd1;

    // Rate ratio, decided from the two rate registers
    typedef enum logic [1:0] {
        MODE_DECIM,   // input rate twice output rate
        MODE_PASS,    // equal rates
        MODE_UP,      // output rate twice input rate
        MODE_GEN      // any other ratio, phase accumulators
    } t_mode;

    // Source of an emitted item
    typedef enum logic [1:0] {
        OSEL_X,       // current input
        OSEL_MID,     // midpoint of previous and current input
        OSEL_INT      // interpolated value
    } t_osel;

    typedef struct packed {
        logic  load;          // latch input, phase difference and |prev - x|
        logic  ip_inc;        // input counter step (decimate mode)
        logic  div_ph_start;  // divider: phase difference / input rate
        logic  div_iq_start;  // divider: product / output rate
        logic  div_step;
        logic  mul_lo;
        logic  mul_hi;
        logic  mul_sum;
        logic  ph_save;       // keep phase remainder and output count
        logic  next_k;        // move to next interpolation point
        logic  emit;
        t_osel emit_sel;
        logic  emit_last;
        logic  prev_upd;      // previous sample takes current input
        logic  ph_adv;        // input phase advance and previous sample update
        logic  ph_sync;       // phase realignment after interpolation
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  ip_odd;
        logic  d_neg;
        logic  div_done;
        logic  k_last;
        logic  out_free;
    } t_status;

endpackage

// ===== rtl/linear_interp_resampler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_interp_resampler_unit : linear-interpolation sample rate converter
// Usage:
//  - Input channel i_in_valid/o_in_ready carries one signed sample per item.
//  - Output channel o_out_valid/i_out_ready carries resampled items; the
//    o_last_of_run flag marks the final item caused by one input item.
//  - The user writes rates via i_cfg_we/i_cfg_idx/i_cfg_data (index 0 input
//    rate, index 1 output rate) only while the block is idle; it has no check.
//  - One item is worked at a time. In general mode an item with no output
//    only advances the input phase and previous sample; else the radix-16
//    divider does one phase division, then for each output a two-slice
//    multiply and a division of QB quotient bits, QB being SAMPLE_BITS + 1
//    rounded up to a multiple of 4.
//  - A result sits in the output register while the next item is taken.
//    When the receiver stalls and a second result is due, the sequencer
//    waits with o_in_ready low.
//  - Synchronous reset: rates return to 1, phases and previous sample to 0,
//    output register empty.
// ----------------------------------------------------------------------------
module linear_interp_resampler_unit
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [RATE_BITS-1:0]          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_last_of_run
);

    t_cmd    cmd;
    t_status status;

    lirs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lirs_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_sample   (i_in_sample),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_sample  (o_out_sample),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== rtl/lirs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_ctrl : sequencer of the resampler
// Takes one item at a time, walks it through the mode's steps and issues
// datapath commands; waits on the output register when it is full.
// ----------------------------------------------------------------------------
module lirs_ctrl
    import lirs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DCHK,
        S_EMIT_MID,
        S_EMIT_X,
        S_EMIT_XP,
        S_GCHK,
        S_GUPD,
        S_PDIV,
        S_PDONE,
        S_MLO,
        S_MHI,
        S_MSUM,
        S_QLOAD,
        S_QDIV,
        S_EMIT_I,
        S_GSYNC
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_status.mode)
                        MODE_DECIM: begin
                            o_cmd.ip_inc = 1'b1;
                            n_state      = S_DCHK;
                        end
                        MODE_PASS: n_state = S_EMIT_X;
                        MODE_UP:   n_state = S_EMIT_MID;
                        MODE_GEN:  n_state = S_GCHK;
                    endcase
                end
            end
            // decimate: keep the item when the counter turned odd
            S_DCHK: begin
                n_state = i_status.ip_odd ? S_EMIT_X : S_IDLE;
            end
            S_EMIT_MID: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = OSEL_MID;
                    n_state        = S_EMIT_XP;
                end
            end
            S_EMIT_X: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = OSEL_X;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_EMIT_XP: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = OSEL_X;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.prev_upd  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            // general mode: output phase ahead means no output this item
            S_GCHK: begin
                if (i_status.d_neg) begin
                    n_state = S_GUPD;
                end else begin
                    o_cmd.div_ph_start = 1'b1;
                    n_state            = S_PDIV;
                end
            end
            S_GUPD: begin
                o_cmd.ph_adv = 1'b1;
                n_state      = S_IDLE;
            end
            S_PDIV: begin
                if (i_status.div_done) begin
                    n_state = S_PDONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_PDONE: begin
                o_cmd.ph_save = 1'b1;
                n_state       = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MSUM;
            end
            S_MSUM: begin
                o_cmd.mul_sum = 1'b1;
                n_state       = S_QLOAD;
            end
            S_QLOAD: begin
                o_cmd.div_iq_start = 1'b1;
                n_state            = S_QDIV;
            end
            S_QDIV: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT_I;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EMIT_I: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = OSEL_INT;
                    o_cmd.emit_last = i_status.k_last;
                    if (i_status.k_last) begin
                        n_state = S_GSYNC;
                    end else begin
                        o_cmd.next_k = 1'b1;
                        n_state      = S_MLO;
                    end
                end
            end
            S_GSYNC: begin
                o_cmd.ph_sync = 1'b1;
                n_state       = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/lirs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_dpath : datapath of the resampler
// Rate registers, phase accumulators, previous sample, a two-slice multiplier,
// a shared radix-16 restoring divider and the output register.
// ----------------------------------------------------------------------------
module lirs_dpath
    import lirs_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [RATE_BITS-1:0]          i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    output logic                          o_last_of_run
);

    // quotient bits kept for the interpolation term (covers the sample range + 1)
    localparam int QB         = ((SAMPLE_BITS + DIV_STEP_BITS) / DIV_STEP_BITS) * DIV_STEP_BITS;
    localparam int DW         = (QB > PH_BITS) ? QB : PH_BITS;
    localparam int DCW        = $clog2(DW / DIV_STEP_BITS + 1);
    localparam int DB         = PH_BITS - 1;            // non-negative phase difference
    localparam int HI_BITS    = DB - MUL_SPLIT;
    localparam int PW         = DB + SAMPLE_BITS;       // product width
    localparam int KW         = $clog2(MAX_OUTPUTS);
    localparam int PH_DIV_CYC = PH_BITS / DIV_STEP_BITS;
    localparam int IQ_DIV_CYC = QB / DIV_STEP_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [QB+1:0]          SUM_MAX = (QB+2)'(SMP_MAX);
    localparam logic signed [QB+1:0]          SUM_MIN = (QB+2)'(SMP_MIN);

    // architectural state
    logic [RATE_BITS-1:0]          r_in_rate;
    logic [RATE_BITS-1:0]          r_out_rate;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic [PH_BITS-1:0]            r_ip;
    logic [PH_BITS-1:0]            r_op;

    // working registers
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [SAMPLE_BITS-1:0]        r_am;
    logic                          r_mneg;
    logic [PH_BITS-1:0]            r_dk;
    logic [MUL_SPLIT+SAMPLE_BITS-1:0] r_plo;
    logic [HI_BITS+SAMPLE_BITS-1:0]   r_phi;
    logic [PW-1:0]                 r_prod;
    logic [RATE_BITS-1:0]          r_div;
    logic [RATE_BITS-1:0]          r_rem;
    logic [DW-1:0]                 r_q;
    logic [DCW-1:0]                r_dcnt;
    logic                          r_sat;
    logic [RATE_BITS-1:0]          r_phrem;
    logic [KW-1:0]                 r_kleft;

    // output register
    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_smp;
    logic                          r_out_last;

    logic [RATE_BITS-1:0]          fs_eff;
    logic [RATE_BITS-1:0]          ofs_eff;
    t_mode                         mode;
    logic signed [SAMPLE_BITS:0]   m_diff;
    logic [SAMPLE_BITS:0]          m_abs;
    logic [PW-QB-1:0]              p_hi;
    logic [RATE_BITS-1:0]          n_rem;
    logic [DW-1:0]                 n_q;
    logic [RATE_BITS:0]            trial;
    logic signed [SAMPLE_BITS:0]   mid_sum;
    logic signed [SAMPLE_BITS:0]   mid_adj;
    logic signed [QB+1:0]          x_ext;
    logic signed [QB+1:0]          t_mag;
    logic signed [QB+1:0]          t_sgn;
    logic signed [QB+1:0]          int_sum;
    logic signed [SAMPLE_BITS-1:0] n_int;
    logic signed [SAMPLE_BITS-1:0] n_result;
    logic                          out_free;

    // a zero rate counts as one
    assign fs_eff  = (r_in_rate  == '0) ? RATE_BITS'(1) : r_in_rate;
    assign ofs_eff = (r_out_rate == '0) ? RATE_BITS'(1) : r_out_rate;

    // Mode decode, 2:1 first, then 1:1, then 1:2
    always_comb begin
        priority if ({1'b0, fs_eff} == {ofs_eff, 1'b0}) begin
            mode = MODE_DECIM;
        end else if (fs_eff == ofs_eff) begin
            mode = MODE_PASS;
        end else if ({1'b0, ofs_eff} == {fs_eff, 1'b0}) begin
            mode = MODE_UP;
        end else begin
            mode = MODE_GEN;
        end
    end

    // slope term prev - x and its magnitude
    assign m_diff = {r_prev[SAMPLE_BITS-1], r_prev} - {i_in_sample[SAMPLE_BITS-1], i_in_sample};
    assign m_abs  = m_diff[SAMPLE_BITS] ? (~m_diff + 1'b1) : m_diff;

    // Divider: DIV_STEP_BITS restoring steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        trial = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            trial = {n_rem, n_q[DW-1]};
            n_q   = {n_q[DW-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial  = trial - {1'b0, r_div};
                n_q[0] = 1'b1;
            end
            n_rem = trial[RATE_BITS-1:0];
        end
    end

    // high part of the product: quotient bits above QB exist when it reaches the divisor
    assign p_hi = r_prod[PW-1:QB];

    // midpoint, truncated toward zero
    assign mid_sum = {r_prev[SAMPLE_BITS-1], r_prev} + {r_x[SAMPLE_BITS-1], r_x};
    assign mid_adj = mid_sum + {{SAMPLE_BITS{1'b0}}, mid_sum[SAMPLE_BITS]};

    // interpolated value x +/- T, saturated
    assign x_ext   = (QB+2)'(r_x);
    assign t_mag   = {2'b00, r_q[QB-1:0]};
    assign t_sgn   = r_mneg ? -t_mag : t_mag;
    assign int_sum = x_ext + t_sgn;

    always_comb begin
        if (r_sat) begin
            n_int = r_mneg ? SMP_MIN : SMP_MAX;
        end else if (int_sum > SUM_MAX) begin
            n_int = SMP_MAX;
        end else if (int_sum < SUM_MIN) begin
            n_int = SMP_MIN;
        end else begin
            n_int = SAMPLE_BITS'(int_sum);
        end
    end

    // Output select
    always_comb begin
        unique case (i_cmd.emit_sel)
            OSEL_X:   n_result = r_x;
            OSEL_MID: n_result = mid_adj[SAMPLE_BITS:1];
            OSEL_INT: n_result = n_int;
            default:  n_result = r_x;
        endcase
    end

    // Rate registers, phases and previous sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate  <= RATE_BITS'(1);
            r_out_rate <= RATE_BITS'(1);
            r_prev     <= '0;
            r_ip       <= '0;
            r_op       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_INPUT_RATE) begin
                    r_in_rate <= i_cfg_data;
                end else if (i_cfg_idx == CFG_OUTPUT_RATE) begin
                    r_out_rate <= i_cfg_data;
                end
            end
            if (i_cmd.ip_inc) begin
                r_ip <= r_ip + PH_BITS'(1);
            end
            if (i_cmd.prev_upd) begin
                r_prev <= r_x;
            end
            if (i_cmd.ph_adv) begin
                r_ip   <= r_ip + PH_BITS'(ofs_eff);
                r_prev <= r_x;
            end
            // realign: exact hit clears both phases before the advance
            if (i_cmd.ph_sync) begin
                if (r_phrem == '0) begin
                    r_op <= PH_BITS'(fs_eff);
                    r_ip <= PH_BITS'(ofs_eff);
                end else begin
                    r_op <= r_ip - PH_BITS'(r_phrem) + PH_BITS'(fs_eff);
                    r_ip <= r_ip + PH_BITS'(ofs_eff);
                end
                r_prev <= r_x;
            end
        end
    end

    // Divider cycle count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_ph_start) begin
            r_dcnt <= DCW'(PH_DIV_CYC);
        end else if (i_cmd.div_iq_start) begin
            r_dcnt <= DCW'(IQ_DIV_CYC);
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - DCW'(1);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_in_sample;
            r_am   <= m_abs[SAMPLE_BITS-1:0];
            r_mneg <= m_diff[SAMPLE_BITS];
            r_dk   <= r_ip - r_op;
        end
        if (i_cmd.next_k) begin
            r_dk    <= r_dk - PH_BITS'(fs_eff);
            r_kleft <= r_kleft - KW'(1);
        end
        if (i_cmd.mul_lo) begin
            r_plo <= r_dk[MUL_SPLIT-1:0] * r_am;
        end
        if (i_cmd.mul_hi) begin
            r_phi <= r_dk[DB-1:MUL_SPLIT] * r_am;
        end
        if (i_cmd.mul_sum) begin
            r_prod <= PW'(r_plo) + (PW'(r_phi) << MUL_SPLIT);
        end
        if (i_cmd.div_ph_start) begin
            r_div <= fs_eff;
            r_rem <= '0;
            r_q   <= DW'(r_dk) << (DW - PH_BITS);
        end else if (i_cmd.div_iq_start) begin
            r_div <= ofs_eff;
            r_rem <= RATE_BITS'(p_hi);
            r_q   <= DW'(r_prod[QB-1:0]) << (DW - QB);
            r_sat <= (p_hi >= (PW-QB)'(ofs_eff));
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
        // outputs still to make after the current one, capped at MAX_OUTPUTS - 1
        if (i_cmd.ph_save) begin
            r_phrem <= r_rem;
            if (r_q[PH_BITS-1:0] >= PH_BITS'(MAX_OUTPUTS - 1)) begin
                r_kleft <= KW'(MAX_OUTPUTS - 1);
            end else begin
                r_kleft <= r_q[KW-1:0];
            end
        end
    end

    // Output register
    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_smp  <= n_result;
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_sample  = r_out_smp;
    assign o_last_of_run = r_out_last;

    // Status to the controller
    always_comb begin
        o_status          = '0;
        o_status.mode     = mode;
        o_status.ip_odd   = r_ip[0];
        o_status.d_neg    = r_dk[PH_BITS-1];
        o_status.div_done = (r_dcnt == '0);
        o_status.k_last   = (r_kleft == '0);
        o_status.out_free = out_free;
    end

endmodule

// ===== rtl/lirs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lirs_checker : port-level checks of the resampler
// Reset behaviour, single-item sequencing and output hold under stall.
// ----------------------------------------------------------------------------
module lirs_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic signed [SAMPLE_BITS-1:0] o_out_sample,
    input logic                          o_last_of_run
);

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset leaves the block ready for an item
    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still ready after an item was taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_sample) && $stable(o_last_of_run))
        else $error("stalled output changed");

endmodule

bind linear_interp_resampler_unit lirs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lirs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_sample  (o_out_sample),
    .o_last_of_run (o_last_of_run)
);
